// ----- sv/tdss_pkg.sv -----
package tdss_pkg;

   localparam int STATE_BITS = 8;
   localparam int NOW_BITS   = 32;
   localparam int DELAY_BITS = 32;
   localparam int CSR_BITS   = 8;

   typedef enum logic [1:0] {
      OP_STEP      = 2'd0,
      OP_INTERRUPT = 2'd1,
      OP_WRITE     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_GUARD_STATE  = 2'd0,
      CSR_TARGET_STATE = 2'd1,
      CSR_NO_TRANS     = 2'd2,
      CSR_FAILED_STATE = 2'd3
   } csr_index_type;

   localparam logic [STATE_BITS-1:0] GUARD_RESET    = 8'd0;
   localparam logic [STATE_BITS-1:0] TARGET_RESET   = 8'd0;
   localparam logic [STATE_BITS-1:0] NO_TRANS_RESET = 8'd255;
   localparam logic [STATE_BITS-1:0] FAILED_RESET   = 8'd254;

   typedef struct packed {
      logic [STATE_BITS-1:0] guard_state;
      logic [STATE_BITS-1:0] target_state;
      logic [STATE_BITS-1:0] no_trans_code;
      logic [STATE_BITS-1:0] failed_code;
   } cfg_type;

   typedef struct packed {
      logic [STATE_BITS-1:0] success;
      logic [STATE_BITS-1:0] failure;
      logic [DELAY_BITS-1:0] delay;
   } entry_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [NOW_BITS-1:0]   now_ms;
      logic                  action_result;
      logic [STATE_BITS-1:0] entry_state;
      entry_type             entry;
   } item_type;

   typedef struct packed {
      logic [STATE_BITS-1:0] state_next;
      logic                  done_next;
      logic                  load_time;
      logic                  taken;
      logic                  blocked;
      logic                  changed;
   } step_out_type;

endpackage

// ----- sv/tdss_table.sv -----
module tdss_table #(
   parameter int STATE_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [tdss_pkg::STATE_BITS-1:0] wr_state,
   input  tdss_pkg::entry_type           wr_entry,
   input  logic [tdss_pkg::STATE_BITS-1:0] rd_state,
   output tdss_pkg::entry_type           rd_entry
);
   import tdss_pkg::*;

   localparam int IDX_BITS = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
   localparam logic [STATE_BITS:0] COUNT_EXT = (STATE_BITS+1)'(STATE_COUNT);

   entry_type mem [STATE_COUNT];
   entry_type rd_data_ff;
   logic      rd_ok_ff;

   logic                wr_ok;
   logic                rd_ok;
   logic [IDX_BITS-1:0] wr_idx;
   logic [IDX_BITS-1:0] rd_idx;

   assign wr_ok  = {1'b0, wr_state} < COUNT_EXT;
   assign rd_ok  = {1'b0, rd_state} < COUNT_EXT;
   assign wr_idx = wr_state[IDX_BITS-1:0];
   assign rd_idx = rd_state[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[wr_idx] <= wr_entry;
      end
      // write-through so an entry loaded for the upcoming state is seen at once
      if (wr_en && wr_ok && (wr_idx == rd_idx)) begin
         rd_data_ff <= wr_entry;
      end else begin
         rd_data_ff <= mem[rd_idx];
      end
      rd_ok_ff <= rd_ok;
   end

   // states beyond the table read as an all-zero entry
   assign rd_entry = rd_ok_ff ? rd_data_ff : '0;

endmodule

// ----- sv/tdss_step.sv -----
module tdss_step #(
   parameter int TIME_BITS = 32
) (
   input  tdss_pkg::cfg_type                cfg,
   input  tdss_pkg::item_type               item,
   input  tdss_pkg::entry_type              entry,
   input  logic [tdss_pkg::STATE_BITS-1:0]  present_state,
   input  logic                             action_done,
   input  logic [TIME_BITS-1:0]             entered_at,
   output tdss_pkg::step_out_type           step_out
);
   import tdss_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  dwell;
   logic                  expired;
   logic                  want_move;
   logic [STATE_BITS-1:0] target;

   assign now_t   = TIME_BITS'(item.now_ms);
   assign dwell   = now_t - entered_at;
   assign expired = CMP_BITS'(dwell) > CMP_BITS'(entry.delay);

   always_comb begin
      step_out            = '0;
      step_out.state_next = present_state;
      step_out.done_next  = action_done;
      want_move           = 1'b0;
      target              = present_state;
      unique case (item.operation)
         OP_STEP: begin
            if (present_state == cfg.failed_code) begin
               step_out.blocked = 1'b1;
            end else if (action_done) begin
               if (expired) begin
                  if (entry.success == cfg.no_trans_code) begin
                     // repeat the action: restart the visit in place
                     step_out.load_time = 1'b1;
                     step_out.done_next = 1'b0;
                  end else begin
                     want_move = 1'b1;
                     target    = entry.success;
                  end
               end
            end else begin
               step_out.taken     = 1'b1;
               step_out.done_next = 1'b1;
               if (item.action_result) begin
                  if (entry.delay == '0) begin
                     step_out.done_next = 1'b0;
                     if (entry.success != cfg.no_trans_code) begin
                        want_move = 1'b1;
                        target    = entry.success;
                     end
                  end
               end else begin
                  want_move = 1'b1;
                  target    = entry.failure;
               end
            end
         end
         OP_INTERRUPT: begin
            if (present_state == cfg.guard_state) begin
               want_move = 1'b1;
               target    = cfg.target_state;
            end
         end
         default: begin
         end
      endcase
      // a move to the state already held changes no state and does not restart the timer
      if (want_move && (target != present_state)) begin
         step_out.state_next = target;
         step_out.load_time  = 1'b1;
         step_out.done_next  = 1'b0;
         step_out.changed    = 1'b1;
      end
   end

endmodule

// ----- sv/table_driven_state_sequencer_top.sv -----
// Path: an accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle unless a held result waits on rsp_ready; the entry of
// the next state is read from the table memory's registered port in the same edge that
// updates the state, so it is ready for the following item.
// Reset: synchronous, active high; clears state, timer and the four registers to
// their defaults. Table contents are not cleared and hold garbage until written.
module table_driven_state_sequencer_top #(
   parameter int STATE_COUNT = 256,
   parameter int TIME_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_now_ms,
   input  logic        req_action_result,
   input  logic [7:0]  req_entry_state,
   input  logic [7:0]  req_entry_success,
   input  logic [7:0]  req_entry_failure,
   input  logic [31:0] req_entry_delay,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_state_now,
   output logic        rsp_action_taken,
   output logic        rsp_step_blocked,
   output logic        rsp_state_changed,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import tdss_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   item_type              s1_item_ff;
   logic                  s1_advance;
   logic                  s1_fire;

   logic [STATE_BITS-1:0] present_state_ff;
   logic [STATE_BITS-1:0] present_state_in;
   logic                  action_done_ff;
   logic                  action_done_in;
   logic [TIME_BITS-1:0]  entered_at_ff;
   logic [TIME_BITS-1:0]  entered_at_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATE_BITS-1:0] rsp_state_ff;
   logic                  rsp_taken_ff;
   logic                  rsp_blocked_ff;
   logic                  rsp_changed_ff;

   entry_type             cur_entry;
   entry_type             wr_entry;
   logic                  wr_en;
   step_out_type          step_out;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GUARD_STATE:  cfg_in.guard_state   = csr_write_data;
            CSR_TARGET_STATE: cfg_in.target_state  = csr_write_data;
            CSR_NO_TRANS:     cfg_in.no_trans_code = csr_write_data;
            CSR_FAILED_STATE: cfg_in.failed_code   = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign s1_advance  = !rsp_valid_ff || rsp_ready;
   assign s1_fire     = s1_valid_ff && s1_advance;
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   tdss_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg           (cfg_ff),
      .item          (s1_item_ff),
      .entry         (cur_entry),
      .present_state (present_state_ff),
      .action_done   (action_done_ff),
      .entered_at    (entered_at_ff),
      .step_out      (step_out)
   );

   assign present_state_in = s1_fire ? step_out.state_next : present_state_ff;
   assign action_done_in   = s1_fire ? step_out.done_next : action_done_ff;
   assign entered_at_in    = (s1_fire && step_out.load_time) ?
                             TIME_BITS'(s1_item_ff.now_ms) : entered_at_ff;

   assign wr_en    = s1_fire && (s1_item_ff.operation == OP_WRITE);
   assign wr_entry = s1_item_ff.entry;

   // read address is the state that the next item will see
   tdss_table #(
      .STATE_COUNT (STATE_COUNT)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_state (s1_item_ff.entry_state),
      .wr_entry (wr_entry),
      .rd_state (present_state_in),
      .rd_entry (cur_entry)
   );

   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.guard_state   <= GUARD_RESET;
         cfg_ff.target_state  <= TARGET_RESET;
         cfg_ff.no_trans_code <= NO_TRANS_RESET;
         cfg_ff.failed_code   <= FAILED_RESET;
         s1_valid_ff          <= 1'b0;
         present_state_ff     <= '0;
         action_done_ff       <= 1'b0;
         entered_at_ff        <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         s1_valid_ff      <= s1_valid_in;
         present_state_ff <= present_state_in;
         action_done_ff   <= action_done_in;
         entered_at_ff    <= entered_at_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.operation      <= req_operation;
         s1_item_ff.now_ms         <= req_now_ms;
         s1_item_ff.action_result  <= req_action_result;
         s1_item_ff.entry_state    <= req_entry_state;
         s1_item_ff.entry.success  <= req_entry_success;
         s1_item_ff.entry.failure  <= req_entry_failure;
         s1_item_ff.entry.delay    <= req_entry_delay;
      end
      if (s1_fire) begin
         rsp_state_ff   <= step_out.state_next;
         rsp_taken_ff   <= step_out.taken;
         rsp_blocked_ff <= step_out.blocked;
         rsp_changed_ff <= step_out.changed;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_now     = rsp_state_ff;
   assign rsp_action_taken  = rsp_taken_ff;
   assign rsp_step_blocked  = rsp_blocked_ff;
   assign rsp_state_changed = rsp_changed_ff;

endmodule

// ----- sv/tdss_checker.sv -----
module tdss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_state_now,
   input logic        rsp_action_taken,
   input logic        rsp_step_blocked,
   input logic        rsp_state_changed
);
   import tdss_pkg::*;

   // state reported by the last item delivered; reset state is zero
   logic [STATE_BITS-1:0] last_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_state_ff <= rsp_state_now;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_state_now))
      else $error("result item dropped or changed while stalled");

   a_blocked_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_blocked |-> !rsp_action_taken && !rsp_state_changed)
      else $error("blocked step consumed the action or moved");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_state_changed == (rsp_state_now != last_state_ff)))
      else $error("state_changed disagrees with the state sequence");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

endmodule

bind table_driven_state_sequencer_top tdss_checker u_tdss_checker (.*);
